FILE: rtl/assert_macros.svh
// Assertion helpers for the top-level RTL. Empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked on every rising edge outside reset.
`define PWE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define PWE_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define PWE_ASSERT(lbl, clk, rstn, prop)
`define PWE_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: rtl/pwecd_pkg.sv
`timescale 1ns / 1ps

package pwecd_pkg;

  localparam int unsigned CMD_W   = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned LIMIT_W = 12;
  localparam int unsigned DUR_W   = 15;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned OWN_W   = 7;

  localparam logic [DUR_W-1:0]   SHORT_LOW_MAX = 15'd2;
  localparam logic [DUR_W-1:0]   ECHO_LOW_MIN  = 15'd1;
  localparam logic [DUR_W-1:0]   ECHO_LOW_MAX  = 15'd6;
  localparam logic [7:0]         TOP_BIT       = 8'h80;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 13'd8191;
  localparam logic [3:0]         FULL_BITS     = 4'd8;

  typedef enum logic [1:0] {
    ST_BYTE     = 2'd0,
    ST_DONE     = 2'd1,
    ST_SHORT    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_COMMAND_BITS   = 2'd0,
    CFG_COMMAND_LENGTH = 2'd1,
    CFG_RESPONSE_LIMIT = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command_bits;
    logic [LEN_W-1:0]   command_length;
    logic [LIMIT_W-1:0] response_bit_limit;
  } cfg_t;

  typedef struct packed {
    logic               first_level;
    logic [DUR_W-1:0]   first_duration;
    logic [DUR_W-1:0]   second_duration;
    logic               end_of_capture;
  } symbol_t;

  typedef struct packed {
    logic [COUNT_W-1:0] symbol_count;
    logic               echo_error;
    logic [7:0]         byte_buffer;
    logic [3:0]         bit_position;
    logic [LIMIT_W-1:0] decoded_count;
  } state_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic [3:0]         bits_in_byte;
    status_e            status;
    logic [LIMIT_W-1:0] total_bits;
    logic               is_last;
  } result_t;

endpackage

FILE: rtl/pulse_width_echo_checked_decoder_top.sv
`timescale 1ns / 1ps

// Pulse-width bit decoder with command echo check.
// Input channel (in_valid_i / in_stall_o): one captured line symbol per item.
// Output channel (out_valid_o / out_stall_i): zero or one result per symbol,
// a full response byte or the final status on the end-of-capture symbol.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; index 0 command
// bits, 1 command length, 2 response bit limit. Write only while idle.
// The result is registered: it appears in the cycle after its symbol is taken.
// Throughput: one symbol per cycle unless stalled; decode is one combinational
// pass between the exchange state registers and the result register.
// Stall: the result register holds while out_stall_i is high; in_stall_o rises
// only when that register is full and stalled, so a symbol is taken on the same
// edge that the downstream side drains the pending result.
// Reset: exchange state cleared, output empty, registers at command 0,
// length 1, limit 32. After each end-of-capture the exchange state clears.
module pulse_width_echo_checked_decoder_top #(
  parameter int MAX_COMMAND_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // symbol input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_level_i,
  input  logic [14:0] first_duration_i,
  input  logic [14:0] second_duration_i,
  input  logic        end_of_capture_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic [3:0]  bits_in_byte_o,
  output logic [1:0]  status_o,
  output logic [11:0] total_bits_o,
  output logic        is_last_o
);
  import pwecd_pkg::*;

  `include "assert_macros.svh"

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  symbol_t sym;
  result_t res_d, res_q;
  logic    res_valid_d;
  logic    out_valid_q;
  logic    in_accept;
  logic    out_accept;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.command_bits       <= '0;
      cfg_q.command_length     <= LEN_W'(1);
      cfg_q.response_bit_limit <= LIMIT_W'(32);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_COMMAND_BITS:   cfg_q.command_bits       <= cfg_data_i;
        CFG_COMMAND_LENGTH: cfg_q.command_length     <= cfg_data_i[LEN_W-1:0];
        CFG_RESPONSE_LIMIT: cfg_q.response_bit_limit <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes: output register drains or refills on the same edge.
  assign out_accept = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign sym = '{first_level: first_level_i, first_duration: first_duration_i,
                 second_duration: second_duration_i, end_of_capture: end_of_capture_i};

  pwecd_decode #(
    .MAX_COMMAND_BYTES(MAX_COMMAND_BYTES)
  ) u_decode (
    .cfg_i      (cfg_q),
    .sym_i      (sym),
    .state_i    (state_q),
    .state_o    (state_d),
    .res_valid_o(res_valid_d),
    .res_o      (res_d)
  );

  // Exchange state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= res_valid_d;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded only when a result is produced.
  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = res_q.data_byte;
  assign bits_in_byte_o = res_q.bits_in_byte;
  assign status_o       = res_q.status;
  assign total_bits_o   = res_q.total_bits;
  assign is_last_o      = res_q.is_last;

  // Partial byte never reaches eight between symbols.
  `PWE_NEVER(a_pos_range, clk_i, rst_ni, state_q.bit_position > 4'd7)
  // A non-final result always carries a full byte.
  `PWE_ASSERT(a_mid_full, clk_i, rst_ni,
    out_valid_o && !is_last_o |-> bits_in_byte_o == FULL_BITS && status_o == ST_BYTE)
  // Failed exchanges report empty fields.
  `PWE_ASSERT(a_fail_zero, clk_i, rst_ni,
    out_valid_o && (status_o == ST_SHORT || status_o == ST_MISMATCH)
      |-> data_byte_o == 8'd0 && bits_in_byte_o == 4'd0 && total_bits_o == 12'd0)
  // Input only stalls behind a held result.
  `PWE_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o)
  // End of capture restarts the exchange and yields a final result.
  `PWE_ASSERT(a_end_clear, clk_i, rst_ni,
    in_accept && end_of_capture_i |=> state_q == '0 && out_valid_o && is_last_o)

endmodule

FILE: rtl/pwecd_decode.sv
`timescale 1ns / 1ps

// Per-symbol decode: next exchange state and the optional result.
module pwecd_decode #(
  parameter int MAX_COMMAND_BYTES = 8
) (
  input  pwecd_pkg::cfg_t    cfg_i,
  input  pwecd_pkg::symbol_t sym_i,
  input  pwecd_pkg::state_t  state_i,
  output pwecd_pkg::state_t  state_o,
  output logic               res_valid_o,
  output pwecd_pkg::result_t res_o
);
  import pwecd_pkg::*;

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_COMMAND_BYTES);

  logic [LEN_W-1:0]   len_eff;
  logic [OWN_W-1:0]   own_last;
  logic [OWN_W-1:0]   own;
  logic [DUR_W-1:0]   low;
  logic               one;
  logic               in_echo;
  logic               want;
  logic               echo_bad;
  logic               decode_en;
  logic               byte_full;
  state_t             nxt;

  always_comb begin
    if (cfg_i.command_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg_i.command_length > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = cfg_i.command_length;
    end
  end

  // Echo covers 8*len command bits plus the stop bit.
  assign own_last = {len_eff, 3'b000};
  assign own      = own_last + OWN_W'(1);

  assign low = sym_i.first_level ? sym_i.second_duration : sym_i.first_duration;
  assign one = (low <= SHORT_LOW_MAX);

  assign in_echo = (state_i.symbol_count < COUNT_W'(own));
  // MSB first: bit index 63 - count, i.e. the inverted low six bits.
  assign want = (state_i.symbol_count == COUNT_W'(own_last)) ? 1'b1
              : cfg_i.command_bits[~state_i.symbol_count[5:0]];
  assign echo_bad = (low < ECHO_LOW_MIN) || (low > ECHO_LOW_MAX) || (one != want);

  assign decode_en = !in_echo && !state_i.echo_error
                  && (state_i.decoded_count < cfg_i.response_bit_limit);

  always_comb begin
    nxt = state_i;
    nxt.echo_error = state_i.echo_error | (in_echo & echo_bad);
    if (decode_en) begin
      if (one) begin
        nxt.byte_buffer = state_i.byte_buffer | (TOP_BIT >> state_i.bit_position[2:0]);
      end
      nxt.bit_position  = state_i.bit_position + 4'd1;
      nxt.decoded_count = state_i.decoded_count + LIMIT_W'(1);
    end
    if (state_i.symbol_count != COUNT_MAX) begin
      nxt.symbol_count = state_i.symbol_count + COUNT_W'(1);
    end
  end

  assign byte_full = decode_en && (nxt.bit_position >= FULL_BITS);

  always_comb begin
    state_o     = nxt;
    res_valid_o = 1'b0;
    res_o       = '{data_byte: '0, bits_in_byte: '0, status: ST_BYTE,
                    total_bits: '0, is_last: 1'b0};
    if (sym_i.end_of_capture) begin
      res_valid_o   = 1'b1;
      res_o.is_last = 1'b1;
      if (nxt.symbol_count < COUNT_W'(own)) begin
        res_o.status = ST_SHORT;
      end else if (nxt.echo_error) begin
        res_o.status = ST_MISMATCH;
      end else begin
        res_o.status       = ST_DONE;
        res_o.data_byte    = nxt.byte_buffer;
        res_o.bits_in_byte = nxt.bit_position;
        res_o.total_bits   = nxt.decoded_count;
      end
      state_o = '0;
    end else if (byte_full) begin
      res_valid_o        = 1'b1;
      res_o.data_byte    = nxt.byte_buffer;
      res_o.bits_in_byte = FULL_BITS;
      res_o.total_bits   = nxt.decoded_count;
      state_o.byte_buffer  = '0;
      state_o.bit_position = '0;
    end
  end

endmodule

FILE: tb/sv/pulse_width_echo_checked_decoder_top_tb.sv
`timescale 1ns / 1ps

module pulse_width_echo_checked_decoder_top_tb;
  import pwecd_pkg::*;

  localparam int          MAX_CMD_BYTES = 8;
  localparam int          SETTLE_CYCLES = 4;       // result is registered, shown in the cycle after its symbol
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          RANDOM_ITEMS  = 580;
  localparam int          LONG_RESP     = 100;     // several full bytes in one exchange

  // Shapes of one exchange as the symbol source builds it.
  typedef enum int {
    EX_GOOD,      // correct echo, stop bit, then response bits
    EX_BAD_BIT,   // one echo symbol decodes to the wrong bit
    EX_BAD_LOW,   // one echo symbol has a low phase outside 1..6
    EX_SHORT,     // end mark before the echo is complete
    EX_NOISE      // random symbols
  } ex_kind_e;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i       = CFG_COMMAND_BITS;
  logic [63:0] cfg_data_i        = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic        first_level_i     = 1'b0;
  logic [14:0] first_duration_i  = '0;
  logic [14:0] second_duration_i = '0;
  logic        end_of_capture_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [7:0]  data_byte_o;
  logic [3:0]  bits_in_byte_o;
  logic [1:0]  status_o;
  logic [11:0] total_bits_o;
  logic        is_last_o;

  pulse_width_echo_checked_decoder_top #(
    .MAX_COMMAND_BYTES(MAX_CMD_BYTES)
  ) dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction: register copy and exchange state
  // ---------------------------------------------------------------------------
  logic [63:0] cmd_bits_q = '0;
  logic [3:0]  cmd_len_q  = 4'd1;
  logic [11:0] rx_limit_q = 12'd32;

  logic [12:0] sym_count = '0;
  logic        echo_bad  = 1'b0;
  logic [7:0]  rx_byte   = '0;
  logic [3:0]  rx_pos    = '0;
  logic [11:0] rx_count  = '0;

  symbol_t pending_syms[$];      // built by the stimulus, drained by the driver
  result_t expected_results[$];  // predicted at symbol acceptance

  int          gen_pos = 0;      // position of the next queued symbol in its exchange
  bit          no_idle = 1'b0;
  int          gap_left = 0;
  int          hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned err_count = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;
  int unsigned status_seen[4] = '{default: 0};

  // Echo length in symbols: command bytes (clamped to 1..8) times 8, plus stop.
  function automatic int echo_symbols();
    int len;
    len = (cmd_len_q == 4'd0) ? 1 : int'(cmd_len_q);
    if (len > MAX_CMD_BYTES) len = MAX_CMD_BYTES;
    return len * 8 + 1;
  endfunction

  // Advance the exchange state by one symbol; returns 1 when it yields a result.
  function automatic bit step_decoder(input symbol_t s, output result_t r);
    logic [14:0] low_ticks;
    bit          one_bit;
    bit          want;
    bit          byte_full;
    int          elen;
    low_ticks = s.first_level ? s.second_duration : s.first_duration;
    one_bit   = (low_ticks <= SHORT_LOW_MAX);
    elen      = echo_symbols();
    byte_full = 1'b0;
    r         = '0;

    if (sym_count < elen) begin
      // echo phase: command bits MSB first, then a stop 1
      want = (sym_count == elen - 1) ? 1'b1 : cmd_bits_q[63 - sym_count[5:0]];
      if (low_ticks < ECHO_LOW_MIN || low_ticks > ECHO_LOW_MAX || one_bit != want)
        echo_bad = 1'b1;
    end else if (!echo_bad && rx_count < rx_limit_q) begin
      if (one_bit) rx_byte = rx_byte | (TOP_BIT >> rx_pos[2:0]);
      rx_pos   = rx_pos + 4'd1;
      rx_count = rx_count + 12'd1;
      byte_full = (rx_pos >= FULL_BITS);
    end
    if (sym_count < COUNT_MAX) sym_count = sym_count + 13'd1;

    if (s.end_of_capture) begin
      r.is_last = 1'b1;
      if (sym_count < elen) begin
        r.status = ST_SHORT;
      end else if (echo_bad) begin
        r.status = ST_MISMATCH;
      end else begin
        r.status       = ST_DONE;
        r.data_byte    = rx_byte;
        r.bits_in_byte = rx_pos;
        r.total_bits   = rx_count;
      end
      sym_count = '0;
      echo_bad  = 1'b0;
      rx_byte   = '0;
      rx_pos    = '0;
      rx_count  = '0;
      return 1'b1;
    end
    if (byte_full) begin
      r.status       = ST_BYTE;
      r.data_byte    = rx_byte;
      r.bits_in_byte = FULL_BITS;
      r.total_bits   = rx_count;
      rx_byte = '0;
      rx_pos  = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [14:0] rand_dur();
    return 15'($urandom_range(0, 32767));
  endfunction

  // Low phase of a response symbol: about half short (1 bit), rest long.
  function automatic logic [14:0] resp_low();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 15'($urandom_range(0, 2));
    if (r < 9) return 15'($urandom_range(3, 40));
    return rand_dur();
  endfunction

  // Place the low phase first or second according to the level.
  function automatic symbol_t make_sym(input logic [14:0] low, input logic lvl,
                                       input logic [14:0] other);
    symbol_t s;
    s.first_level     = lvl;
    s.first_duration  = lvl ? other : low;
    s.second_duration = lvl ? low : other;
    s.end_of_capture  = 1'b0;
    return s;
  endfunction

  // Called at the falling edge only, so the driver never races a push.
  task automatic push_symbol(input symbol_t s, input bit last);
    s.end_of_capture = last;
    pending_syms.insert(pending_syms.size(), s);
    items_sent++;
    gen_pos = last ? 0 : gen_pos + 1;
  endtask

  // Queue one exchange, continuing from gen_pos if the previous one was left open.
  task automatic queue_exchange(input ex_kind_e kind, input int n_resp, input bit close);
    symbol_t     seq[$];
    int          elen;
    int          bad_at;
    int          cut;
    bit          b;
    logic [14:0] low;
    elen = echo_symbols();
    if (kind == EX_SHORT && gen_pos > elen - 2) kind = EX_GOOD;
    bad_at = (gen_pos < elen) ? $urandom_range(gen_pos, elen - 1) : -1;
    cut    = (kind == EX_SHORT) ? $urandom_range(gen_pos, elen - 2) : elen;

    if (kind == EX_NOISE) begin
      repeat (n_resp + 1)
        seq.insert(seq.size(),
                   make_sym(rand_dur(), 1'($urandom_range(0, 1)), rand_dur()));
    end else begin
      for (int p = gen_pos; p < elen && p <= cut; p++) begin
        b = (p == elen - 1) ? 1'b1 : cmd_bits_q[63 - p];
        if (kind == EX_BAD_BIT && p == bad_at)
          low = b ? 15'($urandom_range(3, 6)) : 15'($urandom_range(1, 2));
        else if (kind == EX_BAD_LOW && p == bad_at)
          low = $urandom_range(0, 1) ? 15'd0 : 15'($urandom_range(7, 32767));
        else
          low = b ? 15'($urandom_range(1, 2)) : 15'($urandom_range(3, 6));
        seq.insert(seq.size(), make_sym(low, 1'($urandom_range(0, 1)), rand_dur()));
      end
      if (kind != EX_SHORT)
        repeat (n_resp)
          seq.insert(seq.size(),
                     make_sym(resp_low(), 1'($urandom_range(0, 1)), rand_dur()));
    end
    if (seq.size() == 0)
      seq.insert(seq.size(), make_sym(resp_low(), 1'($urandom_range(0, 1)), rand_dur()));
    if (kind == EX_SHORT) close = 1'b1;
    foreach (seq[i]) push_symbol(seq[i], close && (i == seq.size() - 1));
  endtask

  // Register write; only called with the block idle. Upper data bits are junk on purpose.
  task automatic write_reg(input cfg_index_e idx, input logic [63:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_COMMAND_BITS:   cmd_bits_q = value;
      CFG_COMMAND_LENGTH: cmd_len_q  = value[3:0];
      CFG_RESPONSE_LIMIT: rx_limit_q = value[11:0];
      default: ;
    endcase
  endtask

  // Idle = nothing queued, nothing on the input, nothing expected; then let
  // the pipeline drain, since a symbol may leave no result behind.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_syms.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Symbol driver: predicts each accepted item, then offers the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : symbol_driver
    symbol_t cur;
    symbol_t nxt;
    result_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        cur = '{first_level: first_level_i, first_duration: first_duration_i,
                second_duration: second_duration_i, end_of_capture: end_of_capture_i};
        if (step_decoder(cur, res)) expected_results.insert(expected_results.size(), res);
      end
      if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_syms.size() != 0) begin
        nxt = pending_syms.pop_front();
        first_level_i     <= nxt.first_level;
        first_duration_i  <= nxt.first_duration;
        second_duration_i <= nxt.second_duration;
        end_of_capture_i  <= nxt.end_of_capture;
        in_valid_i        <= 1'b1;
        gap_left          <= no_idle ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compares against the oldest prediction, stalls at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    result_t want;
    int      n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d data_byte %0d", status_o, data_byte_o);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("data_byte", want.data_byte, data_byte_o);
          check_field("bits_in_byte", want.bits_in_byte, bits_in_byte_o);
          check_field("status", want.status, status_o);
          check_field("total_bits", want.total_bits, total_bits_o);
          check_field("is_last", want.is_last, is_last_o);
          status_seen[want.status]++;
          results_seen++;
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        n = no_idle ? 0 : pick_gap();
        out_stall_i <= (n != 0);
        hold_left   <= (n != 0) ? n - 1 : 0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pulse_width_echo_checked_decoder_top_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [14:0] edge_lows[11];
    logic [63:0] data;
    int unsigned random_start;
    int          phase;
    int          n_resp;
    int unsigned r;
    ex_kind_e    kind;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: command byte A5, one byte echoed, ten-bit limit. The echo is
    // followed by hand-picked lows (extremes, both sides of the 1/0 split);
    // the eleventh response symbol is past the limit and carries the end mark.
    write_reg(CFG_COMMAND_BITS, {8'hA5, $urandom, 24'($urandom)});
    write_reg(CFG_COMMAND_LENGTH, 64'd1);
    write_reg(CFG_RESPONSE_LIMIT, 64'd10);
    settings_used++;
    edge_lows = '{15'd0, 15'd32767, 15'd2, 15'd3, 15'd1, 15'd6,
                  15'd7, 15'd100, 15'd0, 15'd2, 15'd5};
    @(negedge clk_i);
    queue_exchange(EX_GOOD, 0, 1'b0);
    foreach (edge_lows[i])
      push_symbol(make_sym(edge_lows[i], 1'(i % 2), (i % 4 < 2) ? 15'h7FFF : 15'h0000),
                  i == 10);
    // capture too short
    queue_exchange(EX_SHORT, 0, 1'b1);
    wait_idle();

    // Random phases, cycling through register settings including the extremes.
    // The last exchange of a phase is sometimes left open, so the next setting
    // lands in the middle of an exchange.
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      data = {$urandom, $urandom};
      case (phase % 6)
        0: begin
          write_reg(CFG_COMMAND_BITS, 64'd0);
          write_reg(CFG_COMMAND_LENGTH, {data[63:4], 4'd1});
          write_reg(CFG_RESPONSE_LIMIT, {data[63:12], 12'd0});
        end
        1: begin
          write_reg(CFG_COMMAND_BITS, '1);
          write_reg(CFG_COMMAND_LENGTH, {data[63:4], 4'd8});
          write_reg(CFG_RESPONSE_LIMIT, {data[63:12], 12'd4095});
        end
        2: begin
          // length 0 is taken as one byte
          write_reg(CFG_COMMAND_BITS, {$urandom, $urandom});
          write_reg(CFG_COMMAND_LENGTH, {data[63:4], 4'd0});
          write_reg(CFG_RESPONSE_LIMIT, {data[63:12], 12'($urandom_range(1, 40))});
        end
        3: begin
          // length 15 is clamped to eight bytes
          write_reg(CFG_COMMAND_BITS, {$urandom, $urandom});
          write_reg(CFG_COMMAND_LENGTH, {data[63:4], 4'd15});
          write_reg(CFG_RESPONSE_LIMIT, {data[63:12], 12'($urandom_range(0, 4095))});
        end
        default: begin
          write_reg(CFG_COMMAND_BITS, {$urandom, $urandom});
          write_reg(CFG_COMMAND_LENGTH, {data[63:4], 4'($urandom_range(1, 3))});
          write_reg(CFG_RESPONSE_LIMIT, {data[63:12], 12'($urandom_range(1, 64))});
        end
      endcase
      settings_used++;
      phase++;
      no_idle = ($urandom_range(0, 3) == 0);
      @(negedge clk_i);
      for (int x = 0; x < 3; x++) begin
        r = $urandom_range(0, 9);
        if (r < 6)       kind = EX_GOOD;
        else if (r == 6) kind = EX_BAD_BIT;
        else if (r == 7) kind = EX_BAD_LOW;
        else if (r == 8) kind = EX_SHORT;
        else             kind = EX_NOISE;
        r = $urandom_range(0, 9);
        if (r < 7)      n_resp = $urandom_range(0, 20);
        else if (r < 9) n_resp = $urandom_range(20, 70);
        else            n_resp = int'(rx_limit_q) + $urandom_range(0, 8);
        if (n_resp > 200) n_resp = 200;
        queue_exchange(kind, n_resp, (x < 2) || ($urandom_range(0, 3) != 0));
      end
      wait_idle();
    end

    // One longer exchange at full limit: a run of full bytes back to back.
    // Run without idling to keep it quick.
    write_reg(CFG_COMMAND_BITS, {$urandom, $urandom});
    write_reg(CFG_COMMAND_LENGTH, 64'd1);
    write_reg(CFG_RESPONSE_LIMIT, 64'd4095);
    settings_used++;
    no_idle = 1'b1;
    @(negedge clk_i);
    queue_exchange(EX_GOOD, LONG_RESP, 1'b1);
    wait_idle();

    $display("run covered %0d symbols under %0d register settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("results by status: byte %0d, done %0d, too short %0d, echo mismatch %0d",
             status_seen[ST_BYTE], status_seen[ST_DONE], status_seen[ST_SHORT],
             status_seen[ST_MISMATCH]);
    if (err_count == 0)
      $display("pulse_width_echo_checked_decoder_top_tb: clean");
    else
      $display("pulse_width_echo_checked_decoder_top_tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pwecd_pkg.sv
rtl/pwecd_decode.sv
rtl/pulse_width_echo_checked_decoder_top.sv
tb/sv/pulse_width_echo_checked_decoder_top_tb.sv
